// ----- rtl/slq_pkg.sv -----
// slq_pkg: shared constants, types and helpers of the sorted list queue
// used by slq_ctrl and sorted_list_queue_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slq_pkg;

  localparam int DEPTH  = 16;
  localparam int WIDTH  = 32;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);

  // port field widths
  localparam int DATA_W  = 32;
  localparam int POS_W   = 5;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_DESCENDING = 3'd0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT    = 2'd0,
    FUNC_POP_FRONT = 2'd1,
    FUNC_POP_BACK  = 2'd2,
    FUNC_FIND      = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic [CW-1:0]    position;
    logic             found;
    status_t          status;
    logic [CW-1:0]    count;
  } result_t;

  typedef struct packed {
    logic             re;
    logic [AW-1:0]    raddr;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [WIDTH-1:0] wdata;
  } mem_req_t;

  // stored entry e stays ahead of a new value v
  function automatic logic keeps_ahead(input logic desc, input logic [WIDTH-1:0] v,
                                       input logic [WIDTH-1:0] e);
    keeps_ahead = desc ? (v <= e) : (v >= e);
  endfunction

  // ring buffer slot of a logical position
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = (CW + 1)'(head) + (CW + 1)'(idx);
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    phys = sum[AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sorted_list_queue_top.sv -----
// sorted_list_queue_top: stream wrapper, config register and result register
// depends on slq_pkg, slq_ram and slq_ctrl
//
// A queue of up to 16 32-bit values kept sorted (ascending, or descending when
// the descending register at address 0 is set). Each item on the in_ stream is
// one operation selected by in_tuser: insert, pop front, pop back or find; each
// gives exactly one result item on the out_ stream with the value popped, the
// position, the found flag, the status and the count held afterwards.
// Entries live in a ring buffer in one memory with a registered read; the
// sequencer uses its single read or its single write port at most once per cycle.
// Steps per item, from the accepted item to the result:
//   insert:    read and compare entries in order, move the tail up one slot (read, write), put
//   pop front, pop back: read and compare the end entry
//   find:      read and compare entries of the range until a match; none for an empty range
//   refused insert or pop: straight to the result
// A new item is taken once the sequencer is idle, while the last result may
// still sit in the output register. When the receiver stalls, the result is
// held and the next finished result waits in the sequencer.
// Reset (synchronous, rst_n low) empties the queue and clears the register.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_queue_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input items
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [31:0] value, [36:32] range_start, [41:37] range_end, [47:42] zero
  input  wire logic [slq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] func
  input  wire logic [slq_pkg::FUNC_W-1:0]         in_tuser,
  // result items
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [31:0] result_value, [36:32] position, [37] found, [39:38] status,
  // [44:40] count, [47:45] zero
  output logic      [slq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // configuration
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [slq_pkg::CFG_AW-1:0]         cfg_paddr,
  input  wire logic [slq_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic      [slq_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                    cfg_pready
);

  logic                             descending_r;
  logic                             out_valid_r;
  logic [slq_pkg::OUT_TDATA_W-1:0]  out_data_r;
  logic                             res_valid;
  logic                             res_ready;
  slq_pkg::result_t                 res;
  slq_pkg::mem_req_t                mem_req;
  logic [slq_pkg::WIDTH-1:0]        mem_rdata;
  logic [slq_pkg::OUT_TDATA_W-1:0]  res_packed;

  // config register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == slq_pkg::REG_DESCENDING) ?
                      slq_pkg::CFG_DW'(descending_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      descending_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == slq_pkg::REG_DESCENDING) begin
      descending_r <= cfg_pwdata[0];
    end
  end

  slq_ram #(
    .DEPTH(slq_pkg::DEPTH),
    .WIDTH(slq_pkg::WIDTH),
    .AW   (slq_pkg::AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .re   (mem_req.re),
    .raddr(mem_req.raddr),
    .rdata(mem_rdata)
  );

  slq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .descending(descending_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (slq_pkg::func_t'(in_tuser)),
    .in_value  (in_tdata[slq_pkg::WIDTH-1:0]),
    .in_start  (slq_pkg::CW'(in_tdata[36:32])),
    .in_end    (slq_pkg::CW'(in_tdata[41:37])),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  assign res_packed = {3'b000,
                       slq_pkg::POS_W'(res.count),
                       res.status,
                       res.found,
                       slq_pkg::POS_W'(res.position),
                       slq_pkg::DATA_W'(res.value)};

  // output register parts the sequencer from the receiver
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_data_r <= res_packed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/slq_ram.sv -----
// slq_ram: generic one-write one-read synchronous memory, registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module slq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/slq_ctrl.sv -----
// slq_ctrl: sequencer that scans, shifts and updates the sorted ring buffer
// depends on slq_pkg; drives the memory request of slq_ram
`timescale 1ns / 1ps
`default_nettype none

module slq_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          descending,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire slq_pkg::func_t                in_func,
  input  wire logic [slq_pkg::WIDTH-1:0]     in_value,
  input  wire logic [slq_pkg::CW-1:0]        in_start,
  input  wire logic [slq_pkg::CW-1:0]        in_end,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output slq_pkg::result_t                   res,
  output slq_pkg::mem_req_t                  mem_req,
  input  wire logic [slq_pkg::WIDTH-1:0]     mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_MV_RD, S_MV_WR, S_PUT, S_DONE
  } state_t;

  state_t                      state_r, state_nxt;
  logic [slq_pkg::AW-1:0]      head_r, head_nxt;
  logic [slq_pkg::CW-1:0]      fill_r, fill_nxt;
  slq_pkg::func_t              func_r, func_nxt;
  logic [slq_pkg::WIDTH-1:0]   val_r, val_nxt;
  logic [slq_pkg::CW-1:0]      idx_r, idx_nxt;
  logic [slq_pkg::CW-1:0]      lim_r, lim_nxt;
  logic [slq_pkg::CW-1:0]      pos_r, pos_nxt;
  logic [slq_pkg::WIDTH-1:0]   rval_r, rval_nxt;
  logic                        found_r, found_nxt;
  slq_pkg::status_t            status_r, status_nxt;
  logic [slq_pkg::CW-1:0]      idx_inc;
  logic [slq_pkg::CW-1:0]      idx_dec;
  logic [slq_pkg::CW-1:0]      in_lim;

  assign idx_inc = idx_r + 1'b1;
  assign idx_dec = idx_r - 1'b1;
  assign in_lim  = (in_end > fill_r) ? fill_r : in_end;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = '{value: rval_r, position: pos_r, found: found_r,
                       status: status_r, count: fill_r};

  always_comb begin
    mem_req = '0;
    case (state_r)
      S_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = slq_pkg::phys(head_r, idx_r);
      end
      S_MV_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = slq_pkg::phys(head_r, idx_dec);
      end
      S_MV_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = slq_pkg::phys(head_r, idx_r);
        mem_req.wdata = mem_rdata;
      end
      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = slq_pkg::phys(head_r, pos_r);
        mem_req.wdata = val_r;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    func_nxt   = func_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    lim_nxt    = lim_r;
    pos_nxt    = pos_r;
    rval_nxt   = rval_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          val_nxt    = in_value;
          rval_nxt   = '0;
          found_nxt  = 1'b0;
          status_nxt = slq_pkg::STAT_OK;
          pos_nxt    = fill_r;
          idx_nxt    = '0;
          lim_nxt    = in_lim;
          case (in_func)
            slq_pkg::FUNC_INSERT: begin
              if (fill_r == slq_pkg::CW'(slq_pkg::DEPTH)) begin
                status_nxt = slq_pkg::STAT_FULL;
                state_nxt  = S_DONE;
              end else if (fill_r == '0) begin
                pos_nxt   = '0;
                state_nxt = S_PUT;
              end else begin
                state_nxt = S_RD;
              end
            end
            slq_pkg::FUNC_POP_FRONT, slq_pkg::FUNC_POP_BACK: begin
              if (fill_r == '0) begin
                status_nxt = slq_pkg::STAT_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                idx_nxt   = (in_func == slq_pkg::FUNC_POP_BACK) ? fill_r - 1'b1 : '0;
                state_nxt = S_RD;
              end
            end
            default: begin
              idx_nxt = in_start;
              // empty range: nothing searched
              state_nxt = (in_start >= in_lim) ? S_DONE : S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        case (func_r)
          slq_pkg::FUNC_INSERT: begin
            if (slq_pkg::keeps_ahead(descending, val_r, mem_rdata)) begin
              idx_nxt = idx_inc;
              if (idx_inc == fill_r) begin
                pos_nxt   = fill_r;
                state_nxt = S_PUT;
              end else begin
                state_nxt = S_RD;
              end
            end else begin
              // open a gap at idx by moving the tail up one slot
              pos_nxt   = idx_r;
              idx_nxt   = fill_r;
              state_nxt = S_MV_RD;
            end
          end
          slq_pkg::FUNC_POP_FRONT: begin
            rval_nxt  = mem_rdata;
            head_nxt  = slq_pkg::phys(head_r, slq_pkg::CW'(1));
            fill_nxt  = fill_r - 1'b1;
            pos_nxt   = fill_r - 1'b1;
            state_nxt = S_DONE;
          end
          slq_pkg::FUNC_POP_BACK: begin
            rval_nxt  = mem_rdata;
            fill_nxt  = fill_r - 1'b1;
            pos_nxt   = fill_r - 1'b1;
            state_nxt = S_DONE;
          end
          default: begin
            if (mem_rdata == val_r) begin
              found_nxt = 1'b1;
              pos_nxt   = idx_r;
              state_nxt = S_DONE;
            end else if (idx_inc >= lim_r) begin
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = idx_inc;
              state_nxt = S_RD;
            end
          end
        endcase
      end
      S_MV_RD: begin
        state_nxt = S_MV_WR;
      end
      S_MV_WR: begin
        idx_nxt   = idx_dec;
        state_nxt = (idx_dec == pos_r) ? S_PUT : S_MV_RD;
      end
      S_PUT: begin
        fill_nxt  = fill_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
    end
    func_r   <= func_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    lim_r    <= lim_nxt;
    pos_r    <= pos_nxt;
    rval_r   <= rval_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= slq_pkg::CW'(slq_pkg::DEPTH))
    else $error("fill count above depth");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && status_r == slq_pkg::STAT_FULL |-> fill_r == slq_pkg::CW'(slq_pkg::DEPTH))
    else $error("insert refused while not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && status_r == slq_pkg::STAT_EMPTY |-> fill_r == '0)
    else $error("pop refused while entries held");

  a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && found_r |-> pos_r < fill_r)
    else $error("found position outside held entries");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted item produced no work");

endmodule

`default_nettype wire
